// ----- sv/dset_pkg.sv -----
// Shared types and codes for the duration sorted event table.
package dset_pkg;

    localparam int KEY_W = 16;
    localparam int DUR_W = 16;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_DUPLICATE = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    typedef enum logic
    {
        ST_IDLE,
        ST_APPLY
    } state_t;

    // Per-cycle commands broadcast to every cell of the chain.
    typedef struct packed
    {
        logic capture;
        logic ins;
        logic del;
    } cell_ctl_t;

endpackage

// ----- sv/dset_cell.sv -----
// One slot of the sorted table: compares against the request and shifts with its neighbors.
module dset_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dset_pkg::cell_ctl_t       ctl,
    input  logic [dset_pkg::KEY_W-1:0] cmp_key,
    input  logic [dset_pkg::DUR_W-1:0] cmp_dur,
    input  logic [dset_pkg::KEY_W-1:0] new_key,
    input  logic [dset_pkg::DUR_W-1:0] new_dur,
    input  logic [dset_pkg::KEY_W-1:0] left_key,
    input  logic [dset_pkg::DUR_W-1:0] left_dur,
    input  logic                      left_valid,
    input  logic                      left_le,
    input  logic [dset_pkg::KEY_W-1:0] right_key,
    input  logic [dset_pkg::DUR_W-1:0] right_dur,
    input  logic                      right_valid,
    input  logic                      hit_in,
    output logic [dset_pkg::KEY_W-1:0] key,
    output logic [dset_pkg::DUR_W-1:0] dur,
    output logic                      valid,
    output logic                      le,
    output logic                      match,
    output logic                      hit_out
);

    logic [dset_pkg::KEY_W-1:0] key_reg, key_next;
    logic [dset_pkg::DUR_W-1:0] dur_reg, dur_next;
    logic                       valid_reg, valid_next;
    logic                       match_reg, match_next;
    logic                       le_reg, le_next;

    always_comb
    begin
        key_next   = key_reg;
        dur_next   = dur_reg;
        valid_next = valid_reg;
        match_next = match_reg;
        le_next    = le_reg;
        if (ctl.capture)
        begin
            match_next = valid_reg && (key_reg == cmp_key);
            le_next    = valid_reg && (dur_reg <= cmp_dur);
        end
        else if (ctl.ins)
        begin
            // cells holding shorter or equal durations stay; the first other one takes the new entry
            if (!le_reg)
            begin
                valid_next = left_valid;
                if (left_le)
                begin
                    key_next = new_key;
                    dur_next = new_dur;
                end
                else
                begin
                    key_next = left_key;
                    dur_next = left_dur;
                end
            end
        end
        else if (ctl.del)
        begin
            if (hit_in || match_reg)
            begin
                key_next   = right_key;
                dur_next   = right_dur;
                valid_next = right_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        dur_reg <= dur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
            le_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
            le_reg    <= le_next;
        end
    end

    assign key     = key_reg;
    assign dur     = dur_reg;
    assign valid   = valid_reg;
    assign le      = le_reg;
    assign match   = match_reg;
    assign hit_out = hit_in || match_reg;

endmodule

// ----- sv/duration_sorted_event_table.sv -----
// Top level of the duration sorted event table: request control, cell chain and result register.
//
// Requests arrive on the in channel (op, event_key, duration) with in_valid/in_stall.
// op add inserts an entry behind all entries of equal or smaller duration, query
// reports a key's duration, delete removes the key and closes the gap.
// One result per request leaves on the out channel with out_valid/out_stall.
// Each request runs through the idle and apply states: the transfer cycle lets every cell
// compare its key and duration, then the apply state shifts the chain and loads the result
// register. A new request is taken only after the result register has been loaded.
// in_stall is high during the shift cycle. If a result still waits under out_stall,
// the shift cycle is held (and in_stall stays high) until the result is taken.
// Reset clears all valid bits and the entry count; no clearing pass is needed.
module duration_sorted_event_table
#(
    parameter int TABLE_DEPTH = 16,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 op,
    input  logic [dset_pkg::KEY_W-1:0] event_key,
    input  logic [dset_pkg::DUR_W-1:0] duration,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 status,
    output logic                       found,
    output logic [dset_pkg::DUR_W-1:0] found_duration,
    output logic [CW-1:0]              entry_count
);

    dset_pkg::state_t state_reg, state_next;
    dset_pkg::cell_ctl_t ctl;

    logic [1:0]                 op_reg;
    logic [dset_pkg::KEY_W-1:0] key_reg;
    logic [dset_pkg::DUR_W-1:0] dur_reg;
    logic [CW-1:0]              count_reg, count_next;

    logic                       out_valid_reg, out_valid_next;
    logic [1:0]                 status_reg, status_next;
    logic                       found_reg, found_next;
    logic [dset_pkg::DUR_W-1:0] fdur_reg, fdur_next;

    logic [dset_pkg::KEY_W-1:0] cell_key [TABLE_DEPTH];
    logic [dset_pkg::DUR_W-1:0] cell_dur [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]     cell_valid;
    logic [TABLE_DEPTH-1:0]     cell_le;
    logic [TABLE_DEPTH-1:0]     cell_match;
    logic [TABLE_DEPTH:0]       hit_chain;

    logic                       accept;
    logic                       load;
    logic                       any_match;
    logic                       full;
    logic [dset_pkg::DUR_W-1:0] match_dur;

    assign accept    = in_valid && (state_reg == dset_pkg::ST_IDLE);
    assign load      = (state_reg == dset_pkg::ST_APPLY) && !(out_valid_reg && out_stall);
    assign any_match = |cell_match;
    assign full      = (count_reg == CW'(TABLE_DEPTH));

    always_comb
    begin
        match_dur = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            match_dur = match_dur | (cell_match[i] ? cell_dur[i] : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dset_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        count_next     = count_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        fdur_next      = fdur_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;
        unique case (state_reg)
            dset_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                ctl.capture = in_valid;
                if (accept)
                begin
                    state_next = dset_pkg::ST_APPLY;
                end
            end
            dset_pkg::ST_APPLY:
            begin
                if (load)
                begin
                    state_next     = dset_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = dset_pkg::STATUS_OK;
                    found_next     = 1'b0;
                    fdur_next      = '0;
                    priority if (op_reg == dset_pkg::OP_ADD)
                    begin
                        if (any_match)
                        begin
                            status_next = dset_pkg::STATUS_DUPLICATE;
                        end
                        else if (full)
                        begin
                            status_next = dset_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            ctl.ins    = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (op_reg == dset_pkg::OP_QUERY || op_reg == dset_pkg::OP_DELETE)
                    begin
                        if (any_match)
                        begin
                            found_next = 1'b1;
                            fdur_next  = match_dur;
                            if (op_reg == dset_pkg::OP_DELETE)
                            begin
                                ctl.del    = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            status_next = dset_pkg::STATUS_NOT_FOUND;
                        end
                    end
                    else
                    begin
                        // unused op code: no change
                        status_next = dset_pkg::STATUS_OK;
                    end
                end
            end
            default:
            begin
                state_next = dset_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op;
            key_reg <= event_key;
            dur_reg <= duration;
        end
        status_reg <= status_next;
        found_reg  <= found_next;
        fdur_reg   <= fdur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign hit_chain[0] = 1'b0;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        logic [dset_pkg::KEY_W-1:0] l_key, r_key;
        logic [dset_pkg::DUR_W-1:0] l_dur, r_dur;
        logic                       l_valid, l_le, r_valid;

        if (g == 0)
        begin : g_first
            // the head cell always sees an occupied, shorter neighbor on its left
            assign l_key   = key_reg;
            assign l_dur   = dur_reg;
            assign l_valid = 1'b1;
            assign l_le    = 1'b1;
        end
        else
        begin : g_mid_l
            assign l_key   = cell_key[g-1];
            assign l_dur   = cell_dur[g-1];
            assign l_valid = cell_valid[g-1];
            assign l_le    = cell_le[g-1];
        end

        if (g == TABLE_DEPTH - 1)
        begin : g_last
            assign r_key   = cell_key[g];
            assign r_dur   = cell_dur[g];
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_key   = cell_key[g+1];
            assign r_dur   = cell_dur[g+1];
            assign r_valid = cell_valid[g+1];
        end

        dset_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .cmp_key     (event_key),
            .cmp_dur     (duration),
            .new_key     (key_reg),
            .new_dur     (dur_reg),
            .left_key    (l_key),
            .left_dur    (l_dur),
            .left_valid  (l_valid),
            .left_le     (l_le),
            .right_key   (r_key),
            .right_dur   (r_dur),
            .right_valid (r_valid),
            .hit_in      (hit_chain[g]),
            .key         (cell_key[g]),
            .dur         (cell_dur[g]),
            .valid       (cell_valid[g]),
            .le          (cell_le[g]),
            .match       (cell_match[g]),
            .hit_out     (hit_chain[g+1])
        );
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found          = found_reg;
    assign found_duration = fdur_reg;
    assign entry_count    = count_reg;

    a_ins_del_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.ins && ctl.del))
        else $error("insert and delete in the same cycle");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("valid bits disagree with entry count");

    a_key_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dset_pkg::ST_APPLY) |-> $onehot0(cell_match))
        else $error("key held in more than one cell");

    a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.del |=> (count_reg + 1'b1 == $past(count_reg)))
        else $error("delete did not drop the count by one");

endmodule

// ----- tb/sv/duration_sorted_event_table_tb.sv -----
// Testbench for the duration sorted event table: random and directed requests, scoreboard check.
`timescale 1ns / 100ps

module duration_sorted_event_table_tb;

    localparam int KEY_W = dset_pkg::KEY_W;
    localparam int DUR_W = dset_pkg::DUR_W;
    localparam int DEPTH = 16;
    localparam int LIMIT = 200000;
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct
    {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [DUR_W-1:0] dur;
        bit               drain;
    } request_t;

    typedef struct
    {
        logic [1:0]       status;
        logic             found;
        logic [DUR_W-1:0] dur;
        logic [4:0]       count;
    } reply_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [1:0]       op = dset_pkg::OP_ADD;
    logic [KEY_W-1:0] event_key = '0;
    logic [DUR_W-1:0] duration = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [1:0]       status;
    logic             found;
    logic [DUR_W-1:0] found_duration;
    logic [4:0]       entry_count;

    request_t         request_q[$];
    reply_t           reply_q[$];

    // shadow copy of the table
    logic [KEY_W-1:0] tbl_keys[DEPTH];
    logic [DUR_W-1:0] tbl_durs[DEPTH];
    int               tbl_held = 0;

    logic [KEY_W-1:0] key_pool[24];
    int               sent_total = 0;
    int               recv_total = 0;
    int               mismatches = 0;
    int               cycles = 0;
    int               n_add = 0, n_query = 0, n_delete = 0, n_none = 0;
    int               n_dup = 0, n_full = 0, n_hit = 0, n_miss = 0, deepest = 0;

    duration_sorted_event_table #(.TABLE_DEPTH(DEPTH)) DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .event_key      (event_key),
        .duration       (duration),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .found          (found),
        .found_duration (found_duration),
        .entry_count    (entry_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic reply_t apply_table_op(logic [1:0] code, logic [KEY_W-1:0] key,
                                              logic [DUR_W-1:0] dur);
        reply_t r;
        int     hit;
        int     pos;
        int     i;
        r.status = dset_pkg::STATUS_OK;
        r.found  = 1'b0;
        r.dur    = '0;
        hit = -1;
        for (i = 0; i < tbl_held; i++)
            if (hit < 0 && tbl_keys[i] == key)
                hit = i;
        if (code == dset_pkg::OP_ADD)
        begin
            n_add++;
            if (hit >= 0)
            begin
                r.status = dset_pkg::STATUS_DUPLICATE;
                n_dup++;
            end
            else if (tbl_held >= DEPTH)
            begin
                r.status = dset_pkg::STATUS_FULL;
                n_full++;
            end
            else
            begin
                // new entry goes behind all equal durations
                pos = 0;
                while (pos < tbl_held && tbl_durs[pos] <= dur)
                    pos++;
                for (i = tbl_held; i > pos; i--)
                begin
                    tbl_keys[i] = tbl_keys[i - 1];
                    tbl_durs[i] = tbl_durs[i - 1];
                end
                tbl_keys[pos] = key;
                tbl_durs[pos] = dur;
                tbl_held++;
            end
        end
        else if (code == dset_pkg::OP_QUERY || code == dset_pkg::OP_DELETE)
        begin
            if (code == dset_pkg::OP_QUERY)
                n_query++;
            else
                n_delete++;
            if (hit < 0)
            begin
                r.status = dset_pkg::STATUS_NOT_FOUND;
                n_miss++;
            end
            else
            begin
                n_hit++;
                r.found = 1'b1;
                r.dur   = tbl_durs[hit];
                if (code == dset_pkg::OP_DELETE)
                begin
                    for (i = hit; i + 1 < tbl_held; i++)
                    begin
                        tbl_keys[i] = tbl_keys[i + 1];
                        tbl_durs[i] = tbl_durs[i + 1];
                    end
                    tbl_held--;
                end
            end
        end
        else
            n_none++;
        if (tbl_held > deepest)
            deepest = tbl_held;
        r.count = tbl_held[4:0];
        return r;
    endfunction

    task automatic queue_request(logic [1:0] code, logic [KEY_W-1:0] key,
                                 logic [DUR_W-1:0] dur, bit drain);
        request_t q;
        q.op    = code;
        q.key   = key;
        q.dur   = dur;
        q.drain = drain;
        request_q.push_back(q);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 80)
            return key_pool[$urandom_range(23)];
        return KEY_W'($urandom);
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return DUR_W'($urandom_range(7));
        if (r < 85)
            return DUR_W'($urandom);
        if (r < 92)
            return '0;
        return '1;
    endfunction

    // sender: one transfer per accepted request, prediction at acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            op        <= dset_pkg::OP_ADD;
            event_key <= '0;
            duration  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                reply_q.push_back(apply_table_op(op, event_key, duration));
                sent_total++;
            end
            if (!in_valid || !in_stall)
            begin
                if (request_q.size() > 0 && !(request_q[0].drain && reply_q.size() > 0)
                    && ((sent_total >= 150 && sent_total < 260) || $urandom_range(99) >= 13))
                begin
                    in_valid  <= 1'b1;
                    op        <= request_q[0].op;
                    event_key <= request_q[0].key;
                    duration  <= request_q[0].dur;
                    void'(request_q.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: compare each result transfer with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                recv_total++;
                if (reply_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result st=%0d f=%0d d=%h n=%0d",
                                 status, found, found_duration, entry_count);
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (status !== want.status || found !== want.found
                        || found_duration !== want.dur || entry_count !== want.count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: #%0d exp %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                                     recv_total, want.status, want.found, want.dur,
                                     want.count, status, found, found_duration,
                                     entry_count);
                    end
                end
            end
            out_stall <= !(recv_total >= 150 && recv_total < 260) && ($urandom_range(99) < 13);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycles, reply_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int seg;
        int n;
        int r;
        int add_pct;
        int del_pct;
        logic [1:0] code;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (n = 2; n < 24; n++)
            key_pool[n] = KEY_W'($urandom);

        // empty table, unused op code, ties, duplicates and a table filled to capacity
        queue_request(dset_pkg::OP_QUERY, 16'h0000, 16'h1111, 1'b0);
        queue_request(dset_pkg::OP_DELETE, 16'hFFFF, 16'h0000, 1'b0);
        queue_request(OP_NONE, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_request(dset_pkg::OP_ADD, 16'h0000, 16'hFFFF, 1'b0);
        queue_request(dset_pkg::OP_ADD, 16'hFFFF, 16'h0000, 1'b0);
        queue_request(dset_pkg::OP_ADD, 16'h0000, 16'h0005, 1'b0);
        queue_request(dset_pkg::OP_ADD, 16'h1234, 16'hFFFF, 1'b0);
        queue_request(dset_pkg::OP_ADD, 16'h0005, 16'h0000, 1'b0);
        queue_request(dset_pkg::OP_QUERY, 16'h0000, 16'hABCD, 1'b0);
        queue_request(dset_pkg::OP_DELETE, 16'hFFFF, 16'h0000, 1'b0);
        queue_request(dset_pkg::OP_QUERY, 16'hFFFF, 16'h0000, 1'b0);
        for (n = 0; n < 12; n++)
            queue_request(dset_pkg::OP_ADD, KEY_W'(16'h0100 + n),
                          DUR_W'((n % 3 == 0) ? 16'h0040 : 16'h8000 - n * 16), 1'b0);
        queue_request(dset_pkg::OP_ADD, 16'h5A5A, 16'h0001, 1'b0);
        queue_request(dset_pkg::OP_ADD, 16'h1234, 16'h0001, 1'b0);
        queue_request(dset_pkg::OP_DELETE, 16'h0000, 16'h0000, 1'b0);

        // random phases alternate between filling, draining and a mix
        for (seg = 0; seg < 8; seg++)
        begin
            case (seg % 4)
                0: begin add_pct = 70; del_pct = 12; end
                1: begin add_pct = 40; del_pct = 27; end
                2: begin add_pct = 20; del_pct = 57; end
                default: begin add_pct = 55; del_pct = 20; end
            endcase
            for (n = 0; n < 50; n++)
            begin
                r = $urandom_range(99);
                if (r < 3)
                    code = OP_NONE;
                else if (r < 3 + add_pct)
                    code = dset_pkg::OP_ADD;
                else if (r < 3 + add_pct + del_pct)
                    code = dset_pkg::OP_DELETE;
                else
                    code = dset_pkg::OP_QUERY;
                queue_request(code, pick_key(), pick_duration(), (seg * 50 + n) % 97 == 0);
            end
        end

        while (request_q.size() > 0 || in_valid || reply_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d adds (%0d duplicate, %0d full), %0d queries, %0d deletes",
                 n_add, n_dup, n_full, n_query, n_delete);
        $display("No-ops %0d, key hits %0d, misses %0d, deepest table %0d, checked %0d",
                 n_none, n_hit, n_miss, deepest, recv_total);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

endmodule
